>>> src/nsd_pkg.sv
package nsd_pkg;

  localparam int DEF_NUM_SAMPLES = 32;
  localparam int DEF_DIMS        = 16;

  localparam int SLOT_W     = 5;
  localparam int DIM_W      = 4;
  localparam int DIM_EXT_W  = 7;
  localparam int VALUE_W    = 16;
  localparam int ID_W       = 20;
  localparam int DIST_W     = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int ACT_SAMPLES_W = 6;
  localparam int ACT_DIMS_W    = 5;

  localparam logic [ACT_SAMPLES_W-1:0] ACT_SAMPLES_RST = 6'd32;
  localparam logic [ACT_DIMS_W-1:0]    ACT_DIMS_RST    = 5'd16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SAMPLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DIMS    = 1'b1;

  typedef struct packed {
    logic               op;
    logic [SLOT_W-1:0]  slot;
    logic [DIM_W-1:0]   dim;
    logic [VALUE_W-1:0] value;
    logic [ID_W-1:0]    point_id;
    logic               last;
  } nsd_req_t;

  typedef struct packed {
    logic [ID_W-1:0]   score_point_id;
    logic [DIST_W-1:0] distance;
  } nsd_res_t;

  typedef struct packed {
    logic               load;
    logic               rd;
    logic [DIM_W-1:0]   dim;
    logic [VALUE_W-1:0] value;
    logic [ID_W-1:0]    id;
    logic               acc;
    logic               clear;
  } nsd_cell_ctrl_t;

endpackage

>>> src/nsd_cell.sv
module nsd_cell import nsd_pkg::*; #(
  parameter int DIMS  = DEF_DIMS,
  parameter int SUM_W = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nsd_cell_ctrl_t       ctrl,
  input  logic                 sel,
  input  logic                 active,
  input  logic [ID_W-1:0]      pid,
  input  logic [SUM_W-1:0]     best_in,
  output logic [SUM_W-1:0]     best_out
);

  localparam int AW = (DIMS > 1) ? $clog2(DIMS) : 1;

  logic [VALUE_W-1:0]   coord_mem [DIMS];
  logic [DIM_EXT_W-1:0] dim_ext;
  logic [AW-1:0]        addr;
  logic [VALUE_W-1:0]   rd_coord;
  logic [VALUE_W-1:0]   q_value;
  logic [ID_W-1:0]      src_id;
  logic [VALUE_W:0]     diff;
  logic [VALUE_W:0]     mag_full;
  logic [VALUE_W-1:0]   mag;
  logic [2*VALUE_W-1:0] prod;
  logic [SUM_W-1:0]     sum;
  logic                 cand;

  assign dim_ext = {{(DIM_EXT_W-DIM_W){1'b0}}, ctrl.dim};
  assign addr    = dim_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      coord_mem[addr] <= ctrl.value;
      src_id          <= ctrl.id;
    end
    if (ctrl.rd) begin
      rd_coord <= coord_mem[addr];
      q_value  <= ctrl.value;
    end
  end

  assign diff     = {q_value[VALUE_W-1], q_value} - {rd_coord[VALUE_W-1], rd_coord};
  assign mag_full = diff[VALUE_W] ? (~diff + 1'b1) : diff;
  assign mag      = mag_full[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    prod <= mag * mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.acc && active) begin
      sum <= sum + SUM_W'(prod);
    end
  end

  assign cand = active && (src_id != pid) && (sum != '0) &&
                ((best_in == '0) || (sum < best_in));

  always_ff @(posedge clk) begin
    best_out <= cand ? sum : best_in;
  end

endmodule

>>> src/nsd_sqrt.sv
module nsd_sqrt import nsd_pkg::*; #(
  parameter int ROOT_W = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   operand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int OP_W = 2 * ROOT_W;
  localparam int CNTW = $clog2(ROOT_W + 1);

  logic              run;
  logic [CNTW-1:0]   cnt;
  logic [OP_W-1:0]   opnd;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+1:0] rem_next;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_sub;
  logic              take;

  assign rem_sh   = {rem[ROOT_W:0], opnd[OP_W-1 -: 2]};
  assign trial    = {1'b0, root, 2'b01};
  assign take     = (rem_sh >= trial);
  assign rem_sub  = rem_sh - trial;
  assign rem_next = take ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(ROOT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= operand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      opnd <= opnd << 2;
      rem  <= rem_next;
      root <= {root[ROOT_W-2:0], take};
    end
  end

endmodule

>>> src/nearest_sample_distance_score_unit.sv
// Nearest sample distance score unit.
// Requests enter on start/req and are taken at a clock edge with start high
// and busy low. A load request (op 0) writes one sample coordinate and the
// sample's source id in its cycle; a query request (op 1) streams one
// coordinate of a query point, and one may follow in every cycle.
// Each sample has its own cell that keeps its coordinates, id and running
// squared distance; the query coordinate is read, squared and summed in a
// three-stage path inside every cell at once.
// A query request with last set raises busy. The running best distance then
// travels down the row of cells, one cell per cycle, and an 18-step
// restoring square root follows at the default widths. The result appears
// as one cycle of done with res, and busy drops in that cycle. The receiver
// cannot stall.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready is high); write them only while no point is being scored.
// Synchronous reset clears all running sums, the control state and sets
// active_samples to 32 and active_dims to 16; sample coordinates and ids
// hold no defined value until loaded.
module nearest_sample_distance_score_unit import nsd_pkg::*; #(
  parameter int NUM_SAMPLES = DEF_NUM_SAMPLES,
  parameter int DIMS        = DEF_DIMS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  nsd_req_t              req,
  output logic                  done,
  output nsd_res_t              res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = 32 + $clog2(DIMS);
  localparam int RW    = (SUM_W + 1) / 2;
  localparam int CW    = $clog2(NUM_SAMPLES + 1);
  localparam int IW    = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam int DCW   = ($clog2(DIMS + 1) > ACT_DIMS_W) ? $clog2(DIMS + 1) : ACT_DIMS_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_ROOT  = 2'd3;

  logic [1:0]               state;
  logic [CW-1:0]            cnt;
  logic                     a_acc;
  logic                     b_acc;
  logic [ACT_SAMPLES_W-1:0] act_samples;
  logic [ACT_DIMS_W-1:0]    act_dims;
  logic [ID_W-1:0]          pid;
  logic                     accept;
  logic                     is_query;
  logic                     dim_ok_load;
  logic                     dim_ok_query;
  logic                     scan_end;
  logic                     root_done;
  logic [RW-1:0]            root;
  logic [SUM_W-1:0]         best [NUM_SAMPLES+1];
  nsd_cell_ctrl_t           ctrl;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_query  = (req.op == OP_QUERY);

  assign dim_ok_load  = DCW'(req.dim) < DCW'(DIMS);
  assign dim_ok_query = (DCW'(req.dim) < DCW'(act_dims)) && dim_ok_load;

  assign scan_end = (state == ST_SCAN) && (cnt == CW'(NUM_SAMPLES));

  always_comb begin
    ctrl.load  = accept && !is_query && dim_ok_load;
    ctrl.rd    = accept && is_query;
    ctrl.dim   = req.dim;
    ctrl.value = req.value;
    ctrl.id    = req.point_id;
    ctrl.acc   = b_acc;
    ctrl.clear = scan_end;
  end

  assign best[0] = '0;

  for (genvar s = 0; s < NUM_SAMPLES; s++) begin : g_cell
    nsd_cell #(
      .DIMS  (DIMS),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sel      (IW'(req.slot) == IW'(s)),
      .active   (IW'(s) < IW'(act_samples)),
      .pid      (pid),
      .best_in  (best[s]),
      .best_out (best[s+1])
    );
  end

  nsd_sqrt #(
    .ROOT_W (RW)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_end),
    .operand ((2*RW)'(best[NUM_SAMPLES])),
    .done    (root_done),
    .root    (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      a_acc       <= 1'b0;
      b_acc       <= 1'b0;
      done        <= 1'b0;
      act_samples <= ACT_SAMPLES_RST;
      act_dims    <= ACT_DIMS_RST;
    end else begin
      a_acc <= accept && is_query && dim_ok_query;
      b_acc <= a_acc;
      done  <= root_done;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ACTIVE_SAMPLES: act_samples <= cfg_data;
          CFG_ACTIVE_DIMS:    act_dims    <= cfg_data[ACT_DIMS_W-1:0];
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && is_query && req.last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!a_acc && !b_acc) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            state <= ST_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // hold the id of the point being scored
  always_ff @(posedge clk) begin
    if (accept && is_query && req.last) begin
      pid <= req.point_id;
    end
    if (root_done) begin
      res.score_point_id <= pid;
      res.distance       <= DIST_W'(root);
    end
  end

endmodule

>>> src/nsd_checker.sv
module nsd_checker import nsd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input nsd_req_t req,
  input logic     done
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without scoring phase");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (req.op == OP_QUERY) && req.last))
    else $error("busy raised without a final query request");

endmodule

bind nearest_sample_distance_score_unit nsd_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done)
);

>>> test/tb_nearest_sample_distance_score_unit.sv
module tb_nearest_sample_distance_score_unit;
  import nsd_pkg::*;

  localparam int NS    = DEF_NUM_SAMPLES;
  localparam int ND    = DEF_DIMS;
  localparam int DRAIN = NS + 40;
  localparam int PHASE_ITEMS = 40;
  localparam int NUM_PHASES  = 9;
  localparam int NUM_ROWS    = 13;

  typedef struct {
    nsd_req_t          r;
    bit                chk;
    logic [DIST_W-1:0] exp_dist;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  nsd_req_t              req = '0;
  logic                  done;
  nsd_res_t              res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [VALUE_W-1:0]       mdl_coord [NS][ND];
  logic [ID_W-1:0]          mdl_id [NS];
  logic [35:0]              mdl_sum [NS];
  logic [ACT_SAMPLES_W-1:0] mdl_ns;
  logic [ACT_DIMS_W-1:0]    mdl_nd;

  nsd_res_t        pending_scores [$];
  nsd_res_t        want;
  int              mismatches = 0;
  int              items_sent = 0;
  int              burst_left = 0;
  int              max_gap = 4;
  logic [ID_W-1:0] id_pool [8];
  dir_row_t        dir_rows [NUM_ROWS];

  nearest_sample_distance_score_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_nearest_sample_distance_score_unit NOT OK");
    $finish;
  end

  function automatic logic [DIST_W-1:0] floor_root(logic [35:0] v);
    logic [DIST_W-1:0] root;
    logic [DIST_W-1:0] cand;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      cand = root | (DIST_W'(1) << b);
      if (longint'(cand) * longint'(cand) <= longint'(v)) root = cand;
    end
    return root;
  endfunction

  task automatic score_coord(input nsd_req_t r, output bit hit, output nsd_res_t o);
    int                 ns_e;
    int                 nd_e;
    logic [35:0]        best;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [VALUE_W-1:0] c;
    hit  = 1'b0;
    o    = '0;
    ns_e = (mdl_ns > NS) ? NS : mdl_ns;
    nd_e = (mdl_nd > ND) ? ND : mdl_nd;
    if (r.op == OP_LOAD) begin
      mdl_coord[r.slot][r.dim] = r.value;
      mdl_id[r.slot] = r.point_id;
      return;
    end
    if (r.dim < nd_e) begin
      for (int s = 0; s < ns_e; s++) begin
        c    = mdl_coord[s][r.dim];
        diff = $signed({r.value[VALUE_W-1], r.value}) - $signed({c[VALUE_W-1], c});
        mag  = (diff < 0) ? -diff : diff;
        mdl_sum[s] = mdl_sum[s] + mag * mag;
      end
    end
    if (!r.last) return;
    best = '0;
    for (int s = 0; s < ns_e; s++) begin
      if (mdl_id[s] == r.point_id) continue;
      if (mdl_sum[s] != 0 && (best == 0 || mdl_sum[s] < best)) best = mdl_sum[s];
    end
    for (int s = 0; s < NS; s++) mdl_sum[s] = '0;
    hit = 1'b1;
    o.score_point_id = r.point_id;
    o.distance = floor_root(best);
  endtask

  task automatic send_req(input nsd_req_t r, input bit chk, input logic [DIST_W-1:0] exp_dist);
    bit       hit;
    nsd_res_t o;
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    score_coord(r, hit, o);
    if (hit) begin
      if (chk) o.distance = exp_dist;
      pending_scores.push_back(o);
    end
    items_sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(input nsd_req_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (max_gap > 0) idle_cycles($urandom_range(0, max_gap));
    end
    burst_left--;
    send_req(r, 1'b0, '0);
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ACTIVE_SAMPLES) mdl_ns = data[ACT_SAMPLES_W-1:0];
    else mdl_nd = data[ACT_DIMS_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic nsd_req_t rand_load();
    nsd_req_t r;
    r.op       = OP_LOAD;
    r.slot     = SLOT_W'($urandom_range(0, NS - 1));
    r.dim      = DIM_W'($urandom_range(0, ND - 1));
    r.value    = rand_value();
    r.point_id = id_pool[$urandom_range(0, 7)];
    r.last     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic logic [ID_W-1:0] rand_pid();
    if ($urandom_range(0, 1) == 0) return id_pool[$urandom_range(0, 7)];
    return ID_W'($urandom);
  endfunction

  function automatic dir_row_t row(logic op, logic [SLOT_W-1:0] slot, logic [DIM_W-1:0] dim,
                                   logic [VALUE_W-1:0] value, logic [ID_W-1:0] pid,
                                   logic last, bit chk, logic [DIST_W-1:0] exp_dist);
    dir_row_t d;
    d.r.op       = op;
    d.r.slot     = slot;
    d.r.dim      = dim;
    d.r.value    = value;
    d.r.point_id = pid;
    d.r.last     = last;
    d.chk        = chk;
    d.exp_dist   = exp_dist;
    return d;
  endfunction

  task automatic run_point(input int nd_e);
    int              order [ND];
    int              n;
    int              j;
    int              t;
    logic [ID_W-1:0] pid;
    nsd_req_t        r;
    pid = rand_pid();
    if ($urandom_range(0, 9) < 8) begin
      n = (nd_e == 0) ? 1 : nd_e;
      for (int i = 0; i < ND; i++) order[i] = (nd_e == 0) ? $urandom_range(0, ND - 1) : i;
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) send_item(rand_load());
        r.op       = OP_QUERY;
        r.slot     = SLOT_W'($urandom);
        r.dim      = DIM_W'(order[i]);
        r.value    = rand_value();
        r.point_id = pid;
        r.last     = (i == n - 1);
        send_item(r);
      end
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        r.op       = OP_QUERY;
        r.slot     = SLOT_W'($urandom);
        r.dim      = DIM_W'($urandom_range(0, ND - 1));
        r.value    = rand_value();
        r.point_id = (i == n - 1) ? pid : rand_pid();
        r.last     = (i == n - 1);
        send_item(r);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected score: id %h distance %0d", res.score_point_id, res.distance);
      end else begin
        want = pending_scores.pop_front();
        if (res.score_point_id !== want.score_point_id || res.distance !== want.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("score mismatch: expected id %h distance %0d, got id %h distance %0d",
                     want.score_point_id, want.distance, res.score_point_id, res.distance);
        end
      end
    end
  end

  initial begin
    int                       phase_end;
    int                       nd_e;
    nsd_req_t                 r;
    logic [ACT_SAMPLES_W-1:0] ns_set [NUM_PHASES];
    logic [ACT_DIMS_W-1:0]    nd_set [NUM_PHASES];

    mdl_ns = ACT_SAMPLES_RST;
    mdl_nd = ACT_DIMS_RST;
    for (int s = 0; s < NS; s++) begin
      mdl_sum[s] = '0;
      mdl_id[s]  = '0;
      for (int d = 0; d < ND; d++) mdl_coord[s][d] = '0;
    end
    for (int i = 0; i < 8; i++) id_pool[i] = ID_W'($urandom);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill every slot so that no query reads an unwritten entry
    for (int s = 0; s < NS; s++) begin
      for (int d = 0; d < ND; d++) begin
        r = rand_load();
        r.slot = SLOT_W'(s);
        r.dim  = DIM_W'(d);
        send_item(r);
      end
    end
    drain();

    write_reg(CFG_ACTIVE_SAMPLES, 6'd1);
    write_reg(CFG_ACTIVE_DIMS, 6'd1);
    dir_rows = '{
      row(OP_LOAD,  5'd0, 4'd0, 16'h8000, 20'd5,       1'b0, 1'b0, '0),
      row(OP_QUERY, 5'd0, 4'd0, 16'h7FFF, 20'd7,       1'b1, 1'b1, 18'd65535),
      row(OP_QUERY, 5'd0, 4'd0, 16'h8000, 20'd7,       1'b1, 1'b1, 18'd0),
      row(OP_QUERY, 5'd0, 4'd0, 16'h7FFF, 20'd5,       1'b1, 1'b1, 18'd0),
      row(OP_QUERY, 5'd0, 4'd1, 16'h7FFF, 20'd7,       1'b1, 1'b1, 18'd0),
      row(OP_QUERY, 5'd0, 4'd0, 16'h8001, 20'd7,       1'b1, 1'b1, 18'd1),
      row(OP_QUERY, 5'd0, 4'd0, 16'h8100, 20'd9,       1'b0, 1'b0, '0),
      row(OP_QUERY, 5'd0, 4'd0, 16'h8100, 20'd9,       1'b1, 1'b0, '0),
      row(OP_LOAD,  5'd0, 4'd0, 16'h0000, 20'd5,       1'b1, 1'b0, '0),
      row(OP_QUERY, 5'd0, 4'd0, 16'h0100, 20'hFFFFF,   1'b0, 1'b0, '0),
      row(OP_LOAD,  5'd0, 4'd0, 16'h0200, 20'd5,       1'b0, 1'b0, '0),
      row(OP_QUERY, 5'd0, 4'd0, 16'hFF00, 20'hFFFFF,   1'b1, 1'b0, '0),
      row(OP_QUERY, 5'd0, 4'd0, 16'h0000, 20'd0,       1'b1, 1'b0, '0)
    };
    for (int i = 0; i < NUM_ROWS; i++)
      send_req(dir_rows[i].r, dir_rows[i].chk, dir_rows[i].exp_dist);
    drain();

    ns_set = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd2, 6'd40,
               ACT_SAMPLES_W'($urandom_range(1, NS)), ACT_SAMPLES_W'($urandom_range(1, NS)),
               6'd32};
    nd_set = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8,
               ACT_DIMS_W'($urandom_range(1, ND)), ACT_DIMS_W'($urandom_range(1, ND)),
               5'd16};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_ACTIVE_SAMPLES, ns_set[p]);
      write_reg(CFG_ACTIVE_DIMS, {1'($urandom), nd_set[p]});
      max_gap   = (p % 3 == 2) ? 0 : ((p % 3 == 1) ? 20 : 3);
      nd_e      = (mdl_nd > ND) ? ND : mdl_nd;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 5) == 0) send_item(rand_load());
        run_point(nd_e);
      end
      drain();
    end

    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("tb_nearest_sample_distance_score_unit OK");
    end else begin
      $display("tb_nearest_sample_distance_score_unit NOT OK");
    end
    $finish;
  end

endmodule
